/* sv/wfde_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package wfde_pkg;

  localparam int unsigned LED_COUNT_DEF = 16;
  localparam int unsigned BITS_PER_LED  = 24;
  localparam int unsigned COLOR_W       = 24;
  localparam int unsigned DUTY_W        = 16;
  localparam int unsigned BIT_IDX_W     = 5;

  localparam logic [DUTY_W-1:0] ONE_DUTY_RST  = 16'd60;
  localparam logic [DUTY_W-1:0] ZERO_DUTY_RST = 16'd30;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic {
    REG_ONE_DUTY  = 1'b0,
    REG_ZERO_DUTY = 1'b1
  } reg_idx_e;

  // 0xRRGGBB -> wire order 0xGGRRBB
  function automatic logic [COLOR_W-1:0] wire_word(input logic [COLOR_W-1:0] rgb);
    return {rgb[15:8], rgb[23:16], rgb[7:0]};
  endfunction

endpackage

`default_nettype wire

/* sv/wfde_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module wfde_ram #(
  parameter  int unsigned Width = 24,
  parameter  int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [AddrW-1:0]         waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [AddrW-1:0]         raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* sv/ws2812_frame_duty_encoder_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// WS2812 frame duty encoder.
// Input channel (in_valid_i / in_stall_o) carries one op per beat: write an LED
// color, start a frame, or a PWM period tick. Only a tick during a frame makes
// an output beat (out_valid_o / out_stall_i): one compare value per color bit,
// LEDs in index order, each LED as G, R, B MSB first, then one closing beat
// with duty 0 and last set, which ends the frame.
// Config channel (cfg_valid_i / cfg_ready_o) sets the one and zero duties;
// ready is always high. Write it only while the block is idle.
// Throughput: one input beat per cycle while the output is not stalled. A tick's
// result is loaded into the output register as the beat is accepted. The color
// store has a registered read port whose address is the LED counter's next value,
// which is what lets every tick find its LED's color already read out.
// While the output register holds a beat and the receiver stalls, in_stall_o
// is high and nothing is accepted; the held beat does not change.
// Reset: all LED colors read as zero (per-entry valid bits), no frame pending
// or in flight, duties back to 60 and 30. No clearing pass is needed.

module ws2812_frame_duty_encoder_unit #(
  parameter int unsigned LED_COUNT = wfde_pkg::LED_COUNT_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,

  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic                          cfg_index_i,
  input  wire logic [wfde_pkg::DUTY_W-1:0]   cfg_data_i,

  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    op_i,
  input  wire logic [7:0]                    led_index_i,
  input  wire logic [wfde_pkg::COLOR_W-1:0]  color_i,

  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [wfde_pkg::DUTY_W-1:0]   duty_o,
  output logic                               last_o
);

  localparam int unsigned LedIdxW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int unsigned BitW    = wfde_pkg::BIT_IDX_W;
  localparam int unsigned DutyW   = wfde_pkg::DUTY_W;
  localparam int unsigned ColorW  = wfde_pkg::COLOR_W;

  logic [DutyW-1:0]     one_duty_q, zero_duty_q;
  logic                 changed_q, changed_d;
  logic                 sending_q, sending_d;
  logic                 closing_q, closing_d;
  logic [LedIdxW-1:0]   led_q, led_d;
  logic [BitW-1:0]      bit_q, bit_d;
  logic [LED_COUNT-1:0] led_vld_q;

  logic                 out_vld_q, out_vld_d;
  logic [DutyW-1:0]     duty_q, duty_d;
  logic                 last_q, last_d;

  logic                 accept;
  logic                 out_load;
  logic                 ram_we;
  logic [ColorW-1:0]    ram_rdata;
  logic [ColorW-1:0]    cur_color;
  logic [ColorW-1:0]    cur_word;
  logic                 cur_bit;
  logic                 idx_ok;
  logic                 last_bit, last_led;
  wfde_pkg::op_e        op;

  assign op          = wfde_pkg::op_e'(op_i);
  assign cfg_ready_o = 1'b1;
  assign out_load    = !out_vld_q || !out_stall_i;
  assign in_stall_o  = !out_load;
  assign accept      = in_valid_i && !in_stall_o;

  assign idx_ok   = {1'b0, led_index_i} < 9'(LED_COUNT);
  assign ram_we   = accept && (op == wfde_pkg::OP_WRITE) && idx_ok && !sending_q;
  assign last_bit = bit_q == BitW'(wfde_pkg::BITS_PER_LED - 1);
  assign last_led = led_q == LedIdxW'(LED_COUNT - 1);

  // Entries never written since reset read as off.
  assign cur_color = led_vld_q[led_q] ? ram_rdata : '0;
  assign cur_word  = wfde_pkg::wire_word(cur_color);
  assign cur_bit   = cur_word[BitW'(wfde_pkg::BITS_PER_LED - 1) - bit_q];

  always_comb begin
    changed_d = changed_q;
    sending_d = sending_q;
    closing_d = closing_q;
    led_d     = led_q;
    bit_d     = bit_q;
    out_vld_d = out_load ? 1'b0 : out_vld_q;
    duty_d    = duty_q;
    last_d    = last_q;
    if (accept) begin
      unique case (op)
        wfde_pkg::OP_WRITE: begin
          if (ram_we) begin
            changed_d = 1'b1;
          end
        end
        wfde_pkg::OP_START: begin
          if (changed_q && !sending_q) begin
            sending_d = 1'b1;
            changed_d = 1'b0;
            closing_d = 1'b0;
            led_d     = '0;
            bit_d     = '0;
          end
        end
        wfde_pkg::OP_TICK: begin
          if (sending_q) begin
            out_vld_d = 1'b1;
            if (closing_q) begin
              duty_d    = '0;
              last_d    = 1'b1;
              sending_d = 1'b0;
              closing_d = 1'b0;
              led_d     = '0;
              bit_d     = '0;
            end else begin
              duty_d = cur_bit ? one_duty_q : zero_duty_q;
              last_d = 1'b0;
              if (last_bit) begin
                bit_d = '0;
                if (last_led) begin
                  closing_d = 1'b1;
                end else begin
                  led_d = LedIdxW'(led_q + 1'b1);
                end
              end else begin
                bit_d = BitW'(bit_q + 1'b1);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_duty_q  <= wfde_pkg::ONE_DUTY_RST;
      zero_duty_q <= wfde_pkg::ZERO_DUTY_RST;
      changed_q   <= 1'b0;
      sending_q   <= 1'b0;
      closing_q   <= 1'b0;
      led_q       <= '0;
      bit_q       <= '0;
      led_vld_q   <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (wfde_pkg::reg_idx_e'(cfg_index_i))
          wfde_pkg::REG_ONE_DUTY:  one_duty_q  <= cfg_data_i;
          wfde_pkg::REG_ZERO_DUTY: zero_duty_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (ram_we) begin
        led_vld_q[led_index_i[LedIdxW-1:0]] <= 1'b1;
      end
      changed_q <= changed_d;
      sending_q <= sending_d;
      closing_q <= closing_d;
      led_q     <= led_d;
      bit_q     <= bit_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    duty_q <= duty_d;
    last_q <= last_d;
  end

  // Read address runs on the next LED index so the data lines up with led_q.
  wfde_ram #(
    .Width (ColorW),
    .Depth (LED_COUNT)
  ) u_color_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (led_index_i[LedIdxW-1:0]),
    .wdata_i (color_i),
    .raddr_i (led_d),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_vld_q;
  assign duty_o      = duty_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire
